// File: sv/hvd_pkg.sv
// Package for the haversine distance pipeline: types, constants and the arctangent table.
`timescale 1ns / 1ps
package hvd_pkg;

    typedef logic signed [30:0] t_lat;
    typedef logic signed [31:0] t_lon;
    typedef logic [24:0]        t_dist;

    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_STEPS   = 31;
    // front end 4, rotation 30, products 6, roots 31, vectoring 30, scaling 1
    localparam int NSTAGE       = 102;

    localparam logic [33:0] CORDIC_K    = 34'd652032874;
    localparam logic [28:0] DEG7_MUL    = 29'd503056907;
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [23:0] DIAMETER_M  = 24'd12742000;
    localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;
    localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;
    localparam logic [60:0] ONE_Q60     = 61'h1000_0000_0000_0000;

    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
        30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
        30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
        30'd31, 30'd15, 30'd7, 30'd3, 30'd1
    };

endpackage

// File: sv/hvd_if.sv
// Handshake interfaces for position pairs in and distances out.
`timescale 1ns / 1ps
interface hvd_in_if;
    logic          valid;
    logic          ready;
    hvd_pkg::t_lat first_lat;
    hvd_pkg::t_lon first_lon;
    hvd_pkg::t_lat second_lat;
    hvd_pkg::t_lon second_lon;
    modport source (output valid, first_lat, first_lon, second_lat, second_lon, input ready);
    modport sink (input valid, first_lat, first_lon, second_lat, second_lon, output ready);
endinterface

interface hvd_out_if;
    logic           valid;
    logic           ready;
    hvd_pkg::t_dist distance_m;
    modport source (output valid, distance_m, input ready);
    modport sink (input valid, distance_m, output ready);
endinterface

// File: sv/haversine_distance.sv
// Top level: great-circle distance between two positions by the haversine formula.
// Throughput: one pair per cycle while the skid word is empty; every CORDIC
// micro-rotation and every root bit has a pipeline stage of its own.
// A two-entry output buffer (output register and skid) lets the pipeline run on
// while a result waits. Reset clears only the valid bits and the buffer's valid flags.
`timescale 1ns / 1ps
module haversine_distance (
    input  logic i_clk,
    input  logic i_rst_n,
    hvd_in_if.sink    i_pos,
    hvd_out_if.source o_dist
);
    import hvd_pkg::*;

    function automatic logic signed [31:0] sat(input logic signed [31:0] v,
                                               input logic signed [31:0] lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    logic              en;
    logic [NSTAGE-1:0] r_vld;
    logic              r_ov, r_sv;
    t_dist             r_od, r_sd;
    t_dist             d_end;

    assign en = !r_sv;
    assign i_pos.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en)  r_vld <= {r_vld[NSTAGE-2:0], i_pos.valid};
    end

    // stage A: saturate
    logic signed [31:0] r_lat1, r_lon1, r_lat2, r_lon2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat1 <= sat(32'(i_pos.first_lat), LAT_LIMIT);
            r_lon1 <= sat(i_pos.first_lon, LON_LIMIT);
            r_lat2 <= sat(32'(i_pos.second_lat), LAT_LIMIT);
            r_lon2 <= sat(i_pos.second_lon, LON_LIMIT);
        end
    end

    // stage B: magnitudes of differences and latitudes
    logic signed [32:0] dlat, dlon;
    logic [31:0] r_mdlat, r_mdlon, r_mlat1, r_mlat2;
    assign dlat = 33'(r_lat2) - 33'(r_lat1);
    assign dlon = 33'(r_lon2) - 33'(r_lon1);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mdlat <= dlat[32] ? 32'(-dlat) : dlat[31:0];
            r_mdlon <= dlon[32] ? 32'(-dlon) : dlon[31:0];
            r_mlat1 <= r_lat1[31] ? -r_lat1 : r_lat1;
            r_mlat2 <= r_lat2[31] ? -r_lat2 : r_lat2;
        end
    end

    // stage C: scale to radians
    logic [60:0] r_pdlat, r_pdlon, r_plat1, r_plat2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pdlat <= 61'(r_mdlat) * 61'(DEG7_MUL);
            r_pdlon <= 61'(r_mdlon) * 61'(DEG7_MUL);
            r_plat1 <= 61'(r_mlat1) * 61'(DEG7_MUL);
            r_plat2 <= 61'(r_mlat2) * 61'(DEG7_MUL);
        end
    end

    // stage D: round, fold the longitude half-angle into the first quadrant
    logic [61:0] hlat_s, hlon_s, alat1_s, alat2_s;
    logic [32:0] hlon;
    logic signed [32:0] r_ang_s1, r_ang_s2, r_ang_c1, r_ang_c2;
    assign hlat_s  = (62'(r_pdlat) + (62'd1 << 28)) >> 29;
    assign hlon_s  = (62'(r_pdlon) + (62'd1 << 28)) >> 29;
    assign alat1_s = (62'(r_plat1) + (62'd1 << 27)) >> 28;
    assign alat2_s = (62'(r_plat2) + (62'd1 << 27)) >> 28;
    assign hlon    = hlon_s[32:0];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_s1 <= $signed(hlat_s[32:0]);
            r_ang_s2 <= (hlon > HALF_PI_Q30) ? $signed(PI_Q30 - hlon) : $signed(hlon);
            r_ang_c1 <= $signed(alat1_s[32:0]);
            r_ang_c2 <= $signed(alat2_s[32:0]);
        end
    end

    logic signed [31:0] s1, s2, c1, c2;
    logic signed [31:0] unused_c_s1, unused_c_s2, unused_s_c1, unused_s_c2;
    hvd_rot u_rot_s1 (.i_clk, .i_en(en), .i_ang(r_ang_s1), .o_cos(unused_c_s1), .o_sin(s1));
    hvd_rot u_rot_s2 (.i_clk, .i_en(en), .i_ang(r_ang_s2), .o_cos(unused_c_s2), .o_sin(s2));
    hvd_rot u_rot_c1 (.i_clk, .i_en(en), .i_ang(r_ang_c1), .o_cos(c1), .o_sin(unused_s_c1));
    hvd_rot u_rot_c2 (.i_clk, .i_en(en), .i_ang(r_ang_c2), .o_cos(c2), .o_sin(unused_s_c2));

    // stages F..K: haversine term a = s1^2 + cos1*cos2*s2^2 in Q60
    logic signed [63:0] r_pcc, r_s1sq_f, r_s1sq_g, r_s1sq_h, r_s1sq_i, r_s1sq_j;
    logic signed [63:0] r_pt, r_pts;
    logic signed [31:0] r_s2_f, r_s2_g, r_s2_h, r_s2_i, r_cc, r_t;
    logic signed [63:0] cc_s, t_s;
    logic signed [64:0] a_s;
    logic [60:0] r_a, r_na;
    assign cc_s = (r_pcc + 64'sd536870912) >>> 30;
    assign t_s  = (r_pt + 64'sd536870912) >>> 30;
    assign a_s  = 65'(r_s1sq_j) + 65'(r_pts);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pcc    <= 64'(c1) * 64'(c2);
            r_s1sq_f <= 64'(s1) * 64'(s1);
            r_s2_f   <= s2;
            r_cc     <= cc_s[31:0];
            r_s1sq_g <= r_s1sq_f;
            r_s2_g   <= r_s2_f;
            r_pt     <= 64'(r_cc) * 64'(r_s2_g);
            r_s1sq_h <= r_s1sq_g;
            r_s2_h   <= r_s2_g;
            r_t      <= t_s[31:0];
            r_s1sq_i <= r_s1sq_h;
            r_s2_i   <= r_s2_h;
            r_pts    <= 64'(r_t) * 64'(r_s2_i);
            r_s1sq_j <= r_s1sq_i;
            if (a_s[64]) begin
                r_a  <= '0;
                r_na <= ONE_Q60;
            end else if (a_s > $signed(65'(ONE_Q60))) begin
                r_a  <= ONE_Q60;
                r_na <= '0;
            end else begin
                r_a  <= a_s[60:0];
                r_na <= ONE_Q60 - a_s[60:0];
            end
        end
    end

    logic [30:0] root_p, root_q;
    hvd_sqrt u_sqrt_p (.i_clk, .i_en(en), .i_val(r_a),  .o_root(root_p));
    hvd_sqrt u_sqrt_q (.i_clk, .i_en(en), .i_val(r_na), .o_root(root_q));

    // vectoring CORDIC: half central angle from (q, p)
    logic signed [33:0] r_vx [CORDIC_STEPS-1];
    logic signed [33:0] r_vy [CORDIC_STEPS-1];
    logic signed [34:0] r_vz [CORDIC_STEPS];

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_vec
        logic signed [33:0] x_in, y_in;
        logic signed [34:0] z_in;
        if (s == 0) begin : g_first
            assign x_in = $signed(34'(root_q));
            assign y_in = $signed(34'(root_p));
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_vx[s-1];
            assign y_in = r_vy[s-1];
            assign z_in = r_vz[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!y_in[33]) r_vz[s] <= z_in + $signed(35'(ATAN_Q30[s]));
                else           r_vz[s] <= z_in - $signed(35'(ATAN_Q30[s]));
            end
        end
        if (s < CORDIC_STEPS - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!y_in[33]) begin
                        r_vx[s] <= x_in + (y_in >>> s);
                        r_vy[s] <= y_in - (x_in >>> s);
                    end else begin
                        r_vx[s] <= x_in - (y_in >>> s);
                        r_vy[s] <= y_in + (x_in >>> s);
                    end
                end
            end
        end
    end

    // stage L: clamp the angle at zero and scale by the earth diameter
    logic signed [34:0] z_end;
    logic [54:0] r_pd;
    logic [54:0] pd_rnd;
    assign z_end = r_vz[CORDIC_STEPS-1];
    always_ff @(posedge i_clk) begin
        if (en) r_pd <= z_end[34] ? '0 : 55'(z_end[30:0]) * 55'(DIAMETER_M);
    end
    assign pd_rnd = (r_pd + (55'd1 << 29)) >> 30;
    assign d_end  = pd_rnd[24:0];

    // output register with skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || o_dist.ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= r_vld[NSTAGE-1];
            end
        end else if (en && r_vld[NSTAGE-1]) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || o_dist.ready) begin
            r_od <= r_sv ? r_sd : d_end;
        end else if (en) begin
            r_sd <= d_end;
        end
    end

    assign o_dist.valid      = r_ov;
    assign o_dist.distance_m = r_od;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid word held without output word");
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv && !o_dist.ready |=> r_sv) else $error("skid word dropped under stall");
    a_end_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[NSTAGE-1] |=> r_ov) else $error("pipeline word lost at output");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld)) else $error("valid bits moved during stall");

endmodule

// File: sv/hvd_rot.sv
// Pipelined rotation CORDIC: one stage per micro-rotation, gives cosine and sine in Q30.
`timescale 1ns / 1ps
module hvd_rot (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_ang,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    import hvd_pkg::*;

    logic signed [33:0] r_x [CORDIC_STEPS];
    logic signed [33:0] r_y [CORDIC_STEPS];
    logic signed [34:0] r_z [CORDIC_STEPS-1];

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [34:0] z_in;
        if (s == 0) begin : g_first
            assign x_in = $signed(CORDIC_K);
            assign y_in = '0;
            assign z_in = 35'(i_ang);
        end else begin : g_next
            assign x_in = r_x[s-1];
            assign y_in = r_y[s-1];
            assign z_in = r_z[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[34]) begin
                    r_x[s] <= x_in - (y_in >>> s);
                    r_y[s] <= y_in + (x_in >>> s);
                end else begin
                    r_x[s] <= x_in + (y_in >>> s);
                    r_y[s] <= y_in - (x_in >>> s);
                end
            end
        end
        if (s < CORDIC_STEPS - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!z_in[34]) r_z[s] <= z_in - $signed(35'(ATAN_Q30[s]));
                    else           r_z[s] <= z_in + $signed(35'(ATAN_Q30[s]));
                end
            end
        end
    end

    assign o_cos = r_x[CORDIC_STEPS-1][31:0];
    assign o_sin = r_y[CORDIC_STEPS-1][31:0];

endmodule

// File: sv/hvd_sqrt.sv
// Pipelined floor square root of a 61-bit value, one result bit per stage.
`timescale 1ns / 1ps
module hvd_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_val,
    output logic [30:0] o_root
);
    import hvd_pkg::*;

    logic [60:0] r_v [ROOT_STEPS-1];
    logic [60:0] r_r [ROOT_STEPS];

    for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
        localparam logic [60:0] BIT = 61'd1 << (60 - 2 * s);
        logic [60:0] v_in;
        logic [60:0] r_in;
        logic [60:0] trial;
        logic        fits;
        if (s == 0) begin : g_first
            assign v_in = i_val;
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_v[s-1];
            assign r_in = r_r[s-1];
        end
        assign trial = r_in + BIT;
        assign fits  = (v_in >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[s] <= fits ? (r_in >> 1) + BIT : (r_in >> 1);
            end
        end
        if (s < ROOT_STEPS - 1) begin : g_v
            always_ff @(posedge i_clk) begin
                if (i_en) r_v[s] <= fits ? v_in - trial : v_in;
            end
        end
    end

    assign o_root = r_r[ROOT_STEPS-1][30:0];

endmodule
